/* src/grp_pkg.sv */
// types, codes and sizes shared by the guillotine rectangle packer
// no dependencies; imported by grp_ram users, grp_fit and guillotine_rect_packer
package grp_pkg;

  localparam int unsigned FREE_SLOTS_DEF = 64;
  localparam int unsigned COORD_W        = 15;
  localparam int unsigned POS_W          = 14;
  localparam int unsigned STATUS_W       = 2;
  localparam int unsigned CFG_W          = 15;
  localparam int unsigned CFG_IDX_W      = 1;
  localparam int unsigned ATLAS_RESET    = 2048;

  typedef logic [COORD_W-1:0]  coord_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam logic REQ_BEGIN = 1'b0;
  localparam logic REQ_PLACE = 1'b1;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_NOFIT = 2'd1;
  localparam status_t ST_FULL  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ATLAS_W = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ATLAS_H = 1'b1;

  // x in the low bits, h in the high bits
  typedef struct packed {
    coord_t h;
    coord_t w;
    coord_t y;
    coord_t x;
  } rect_t;

  typedef struct packed {
    logic   req_type;
    coord_t rect_width;
    coord_t rect_height;
  } req_t;

  typedef struct packed {
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    status_t          status;
  } rsp_t;

  typedef struct packed {
    logic       fit;
    logic [1:0] nadd;
    rect_t      add0;
    rect_t      add1;
  } split_t;

endpackage

/* src/grp_ram.sv */
// generic single write port ram with registered read
// no dependencies
module grp_ram #(
  parameter int unsigned WIDTH = 60,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* src/grp_fit.sv */
// shared fit and split unit: fit test during the scan, remainders after a hit
// depends on grp_pkg
module grp_fit (
  input  grp_pkg::rect_t  entry_i,
  input  grp_pkg::coord_t rw_i,
  input  grp_pkg::coord_t rh_i,
  output grp_pkg::split_t split_o
);
  import grp_pkg::*;

  coord_t sw;
  coord_t sh;
  logic   lt_w;
  logic   lt_h;
  logic   eq_w;
  logic   eq_h;

  always_comb begin
    sw   = entry_i.w - rw_i;
    sh   = entry_i.h - rh_i;
    lt_w = rw_i < entry_i.w;
    lt_h = rh_i < entry_i.h;
    eq_w = rw_i == entry_i.w;
    eq_h = rh_i == entry_i.h;

    split_o.fit  = (rw_i <= entry_i.w) && (rh_i <= entry_i.h);
    split_o.nadd = 2'd0;
    split_o.add0 = '0;
    split_o.add1 = '0;

    if (lt_w && lt_h) begin
      split_o.nadd = 2'd2;
      if (sw > sh) begin
        split_o.add0 = '{h: entry_i.h, w: sw, y: entry_i.y, x: entry_i.x + rw_i};
        split_o.add1 = '{h: sh, w: rw_i, y: entry_i.y + rh_i, x: entry_i.x};
      end else begin
        split_o.add0 = '{h: sh, w: entry_i.w, y: entry_i.y + rh_i, x: entry_i.x};
        split_o.add1 = '{h: rh_i, w: sw, y: entry_i.y, x: entry_i.x + rw_i};
      end
    end else if (eq_w && eq_h) begin
      split_o.nadd = 2'd0;
    end else if (eq_w) begin
      // strip below, full width
      split_o.nadd = 2'd1;
      split_o.add0 = '{h: sh, w: entry_i.w, y: entry_i.y + rh_i, x: entry_i.x};
    end else begin
      // strip to the right, full height
      split_o.nadd = 2'd1;
      split_o.add0 = '{h: entry_i.h, w: sw, y: entry_i.y, x: entry_i.x + rw_i};
    end
  end

endmodule

/* src/guillotine_rect_packer.sv */
// guillotine rectangle packer: free list in a ram, scanned by a small sequencer
// depends on grp_pkg, grp_ram, grp_fit
//
// channel  | direction | handshake               | payload
// in       | input     | in_valid_i / in_ready_o | in_req_i   (req_t)
// out      | output    | out_valid_o / out_ready_i | out_rsp_o (rsp_t)
// cfg      | input     | cfg_we_i, no wait       | cfg_idx_i, cfg_data_i
//
// begin: idle, done. place: scan from the last list entry down to the hit, one ram
// read per cycle, then split, move of the last entry into the hole, one write per
// remainder written, done; list full: scan, split, done; no fit: scan, done, or
// done at once on an empty list. one request at a time; ready only while idle.
// reset: list empty, atlas 2048 x 2048, no clearing pass.
// a stalled result waits in the output register; the next request is taken meanwhile.
module guillotine_rect_packer #(
  parameter int unsigned FREE_SLOTS = grp_pkg::FREE_SLOTS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  grp_pkg::req_t                  in_req_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output grp_pkg::rsp_t                  out_rsp_o,
  input  logic                           cfg_we_i,
  input  logic [grp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [grp_pkg::CFG_W-1:0]      cfg_data_i
);
  import grp_pkg::*;

  localparam int unsigned IW = $clog2(FREE_SLOTS);
  localparam int unsigned CW = $clog2(FREE_SLOTS + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_SPLIT = 3'd2;
  localparam logic [2:0] S_MOVE  = 3'd3;
  localparam logic [2:0] S_WR0   = 3'd4;
  localparam logic [2:0] S_WR1   = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]    state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [IW-1:0] ptr_q, ptr_d;
  logic [IW-1:0] found_q, found_d;
  coord_t        atlas_w_q, atlas_h_q;
  coord_t        rw_q, rw_d, rh_q, rh_d;
  rect_t         hit_q, hit_d;
  split_t        split_q, split_d;
  rsp_t          res_q, res_d;
  logic          out_valid_q, out_valid_d;
  rsp_t          out_rsp_q, out_rsp_d;

  logic          in_fire;
  logic [CW-1:0] cnt_m1;
  logic [CW:0]   need;
  logic          overflow;
  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  rect_t         ram_wdata;
  logic [IW-1:0] ram_raddr;
  rect_t         ram_rdata;
  rect_t         fit_entry;
  split_t        fit_res;

  grp_ram #(
    .WIDTH ($bits(rect_t)),
    .DEPTH (FREE_SLOTS)
  ) u_free_list (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign fit_entry = (state_q == S_SPLIT) ? hit_q : ram_rdata;

  grp_fit u_fit (
    .entry_i (fit_entry),
    .rw_i    (rw_q),
    .rh_i    (rh_q),
    .split_o (fit_res)
  );

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign cnt_m1      = count_q - 1'b1;
  assign need        = {1'b0, count_q} + {{(CW-1){1'b0}}, fit_res.nadd};
  assign overflow    = need > (CW+1)'(FREE_SLOTS + 1);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    ptr_d       = ptr_q;
    found_d     = found_q;
    rw_d        = rw_q;
    rh_d        = rh_q;
    hit_d       = hit_q;
    split_d     = split_q;
    res_d       = res_q;
    ram_we      = 1'b0;
    ram_waddr   = found_q;
    ram_wdata   = ram_rdata;
    ram_raddr   = cnt_m1[IW-1:0];
    out_valid_d = out_valid_q && !out_ready_i;
    out_rsp_d   = out_rsp_q;

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          rw_d  = in_req_i.rect_width;
          rh_d  = in_req_i.rect_height;
          ptr_d = cnt_m1[IW-1:0];
          res_d = '{pos_x: '0, pos_y: '0, status: ST_OK};
          if (in_req_i.req_type == REQ_BEGIN) begin
            ram_we    = 1'b1;
            ram_waddr = '0;
            ram_wdata = '{h: atlas_h_q, w: atlas_w_q, y: '0, x: '0};
            count_d   = CW'(1);
            state_d   = S_DONE;
          end else if (count_q == '0) begin
            res_d.status = ST_NOFIT;
            state_d      = S_DONE;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        ram_raddr = ptr_q - 1'b1;
        if (fit_res.fit) begin
          hit_d   = ram_rdata;
          found_d = ptr_q;
          state_d = S_SPLIT;
        end else if (ptr_q == '0) begin
          count_d      = '0;
          res_d.status = ST_NOFIT;
          state_d      = S_DONE;
        end else begin
          ptr_d = ptr_q - 1'b1;
        end
      end
      S_SPLIT: begin
        // last entry read here, moved into the hole next cycle
        if (overflow) begin
          res_d.status = ST_FULL;
          state_d      = S_DONE;
        end else begin
          split_d = fit_res;
          res_d   = '{pos_x: hit_q.x[POS_W-1:0], pos_y: hit_q.y[POS_W-1:0], status: ST_OK};
          state_d = S_MOVE;
        end
      end
      S_MOVE: begin
        ram_we    = 1'b1;
        ram_waddr = found_q;
        ram_wdata = ram_rdata;
        count_d   = cnt_m1;
        state_d   = (split_q.nadd == 2'd0) ? S_DONE : S_WR0;
      end
      S_WR0: begin
        ram_we    = 1'b1;
        ram_waddr = count_q[IW-1:0];
        ram_wdata = split_q.add0;
        count_d   = count_q + 1'b1;
        state_d   = (split_q.nadd == 2'd2) ? S_WR1 : S_DONE;
      end
      S_WR1: begin
        ram_we    = 1'b1;
        ram_waddr = count_q[IW-1:0];
        ram_wdata = split_q.add1;
        count_d   = count_q + 1'b1;
        state_d   = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_rsp_d   = res_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      atlas_w_q   <= COORD_W'(ATLAS_RESET);
      atlas_h_q   <= COORD_W'(ATLAS_RESET);
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ATLAS_W: atlas_w_q <= cfg_data_i;
          CFG_ATLAS_H: atlas_h_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q     <= ptr_d;
    found_q   <= found_d;
    rw_q      <= rw_d;
    rh_q      <= rh_d;
    hit_q     <= hit_d;
    split_q   <= split_d;
    res_q     <= res_d;
    out_rsp_q <= out_rsp_d;
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(FREE_SLOTS))
    else $error("free list count beyond capacity");

  a_nofit_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && res_q.status == ST_NOFIT) |-> (count_q == '0))
    else $error("no fit left entries in the list");

  a_full_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SPLIT && overflow) |=> (count_q == $past(count_q)))
    else $error("full result changed the list");

  a_begin_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_req_i.req_type == REQ_BEGIN) |=> (count_q == CW'(1)))
    else $error("begin did not leave one free rectangle");

endmodule
